### rtl/whdt_pkg.sv
// ----------------------------------------------------------------------------
// whdt_pkg: shared definitions for the word hash dedup table
// Sizes, status codes and the packed payload types used across the block.
// ----------------------------------------------------------------------------
package whdt_pkg;

	localparam int TABLE_DEPTH  = 1024;
	localparam int MAX_WORD_LEN = 256;

	localparam int HASH_W   = 64;
	localparam int CHAR_W   = 8;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 11;
	localparam int SHIFT_W  = 5;
	localparam int ADDR_W   = $clog2(TABLE_DEPTH);
	localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
	localparam int POS_W    = $clog2(MAX_WORD_LEN + 1);

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_LONG = 2'd2;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [CHAR_W-1:0] char_code;
		logic              char_last;
	} item_t;

	typedef struct packed {
		logic [HASH_W-1:0]   hash_value;
		logic                was_present;
		logic                inserted;
		logic [STATUS_W-1:0] status;
		logic [FILL_W-1:0]   fill_count;
	} result_t;

	// Finished word handed from the hash unit to the table scanner.
	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic              kind;
		logic              overlong;
	} word_t;

endpackage

### rtl/whdt_ram.sv
// ----------------------------------------------------------------------------
// whdt_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module whdt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/whdt_hash.sv
// ----------------------------------------------------------------------------
// whdt_hash: per-character hash accumulator
// Folds one character per cycle, when step is high, into the running
// hash and hands the finished word to the scanner at the last character.
// ----------------------------------------------------------------------------
module whdt_hash
	import whdt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  item_t             item,
	input  logic [HASH_W-1:0] seed,
	output logic              word_valid,
	output word_t             word
);

	logic [HASH_W-1:0]       acc_q;
	logic [POS_W-1:0]        pos_q;
	logic                    ovl_q;
	logic                    word_valid_q;
	word_t                   word_q;

	logic [HASH_W-1:0]       acc_base;
	logic [HASH_W-1:0]       acc_next;
	logic [POS_W+CHAR_W-1:0] prod;
	logic [SHIFT_W-1:0]      sh;
	logic                    too_long;

	assign too_long = (pos_q >= POS_W'(MAX_WORD_LEN));
	assign acc_base = (pos_q == '0 && !ovl_q) ? seed : acc_q;
	assign prod     = (POS_W+CHAR_W)'(pos_q) * (POS_W+CHAR_W)'(item.char_code);
	assign sh       = SHIFT_W'(pos_q);

	always_comb begin
		if (too_long) begin
			acc_next = acc_base;
		end else begin
			acc_next = acc_base + HASH_W'(prod) + (HASH_W'(1) << sh);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			ovl_q        <= 1'b0;
			word_valid_q <= 1'b0;
		end else begin
			word_valid_q <= step && item.char_last;
			if (step) begin
				if (item.char_last) begin
					pos_q <= '0;
					ovl_q <= 1'b0;
				end else if (too_long) begin
					ovl_q <= 1'b1;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			acc_q <= acc_next;
			if (item.char_last) begin
				word_q.hash     <= acc_next;
				word_q.kind     <= item.kind;
				word_q.overlong <= ovl_q || too_long;
			end
		end
	end

	assign word_valid = word_valid_q;
	assign word       = word_q;

endmodule

### rtl/whdt_scan.sv
// ----------------------------------------------------------------------------
// whdt_scan: table scan sequencer
// Walks the filled entries one per cycle through a single comparator and
// appends the hash when an insert finds no match and the table has room.
// ----------------------------------------------------------------------------
module whdt_scan
	import whdt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              word_valid,
	input  word_t             word,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [HASH_W-1:0] rd_data,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [HASH_W-1:0] wr_data,
	output logic              busy,
	output logic              result_valid,
	output result_t           result
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             pend_q;
	logic             res_valid_q;
	result_t          res_q;

	logic             match;
	logic             finish;
	logic             do_insert;
	logic             room;

	assign match     = (state_q == ST_SCAN) && pend_q && (rd_data == word.hash);
	assign finish    = (state_q == ST_SCAN) && (match || rd_idx_q == count_q);
	assign room      = (count_q < CNT_W'(TABLE_DEPTH));
	assign do_insert = finish && !match && (word.kind == KIND_INSERT) && room;

	assign rd_en   = (state_q == ST_SCAN) && (rd_idx_q < count_q) && !match;
	assign rd_addr = rd_idx_q[ADDR_W-1:0];
	assign wr_en   = do_insert;
	assign wr_addr = count_q[ADDR_W-1:0];
	assign wr_data = word.hash;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_idx_q    <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (word_valid) begin
						if (word.overlong) begin
							res_valid_q <= 1'b1;
						end else begin
							state_q  <= ST_SCAN;
							rd_idx_q <= '0;
							pend_q   <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					pend_q <= rd_en;
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (finish) begin
						state_q     <= ST_IDLE;
						res_valid_q <= 1'b1;
						if (do_insert) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && word_valid && word.overlong) begin
			res_q.hash_value  <= word.hash;
			res_q.was_present <= 1'b0;
			res_q.inserted    <= 1'b0;
			res_q.status      <= STATUS_LONG;
			res_q.fill_count  <= FILL_W'(count_q);
		end else if (finish) begin
			res_q.hash_value  <= word.hash;
			res_q.was_present <= match;
			res_q.inserted    <= do_insert;
			res_q.status      <= (!match && word.kind == KIND_INSERT && !room) ?
				STATUS_FULL : STATUS_OK;
			res_q.fill_count  <= do_insert ? FILL_W'(count_q + CNT_W'(1)) : FILL_W'(count_q);
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

### rtl/word_hash_dedup_table_core.sv
// ----------------------------------------------------------------------------
// word_hash_dedup_table_core: word hashing with an insert-if-absent table
// Hashes a word one character at a time and looks up or inserts the hash
// in a table that is scanned linearly.
// ----------------------------------------------------------------------------
// A word enters one character per start pulse; a character is taken at any
// clock edge where start is high and busy is low. Characters that are not
// the last one leave busy low and produce no result. The last character
// raises busy while the finished hash is compared against the stored
// entries, one entry per cycle through one comparator reading the table
// RAM, and a match ends the scan early. An overlong word skips the scan.
// Every word yields exactly one result, shown for one cycle with
// result_valid high; the result cannot be held off, so the receiver
// must take it on that cycle. The seed register may be written only
// while no word is in progress; it is picked up at the first character
// of the next word.
module word_hash_dedup_table_core
	import whdt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	output logic              result_valid,
	output result_t           result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [HASH_W-1:0] cfg_data
);

	logic [HASH_W-1:0] seed_q;
	logic              step;
	logic              word_valid;
	word_t             word;
	logic              scan_busy;

	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [HASH_W-1:0] rd_data;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [HASH_W-1:0] wr_data;

	// A character is taken only while neither a finished word is waiting
	// for the scanner nor a scan is running.
	assign busy      = word_valid || scan_busy;
	assign step      = start && !busy;
	assign cfg_ready = !busy;

	// The seed register resets to zero, like the rest of the control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= cfg_data;
		end
	end

	whdt_hash u_hash (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item),
		.seed      (seed_q),
		.word_valid(word_valid),
		.word      (word)
	);

	// The scanner only ever reads entries below the fill count, so the
	// table needs no clearing after reset.
	whdt_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.word_valid  (word_valid),
		.word        (word),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.busy        (scan_busy),
		.result_valid(result_valid),
		.result      (result)
	);

	whdt_ram #(
		.WIDTH(HASH_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

endmodule

### rtl/whdt_checker.sv
// ----------------------------------------------------------------------------
// whdt_checker: port-level checks for the word hash dedup table
// Watches the top level's ports and flags inconsistent results.
// ----------------------------------------------------------------------------
module whdt_checker
	import whdt_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input logic    result_valid,
	input result_t result
);

	// A result only follows a cycle in which the block was busy.
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a preceding busy cycle");

	// Taking the last character of a word makes the block busy next cycle.
	a_last_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.char_last) |=> busy)
		else $error("last character did not raise busy");

	// A fresh insert is never a hit and always reports a good status.
	a_insert_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.inserted) |->
		(!result.was_present && result.status == STATUS_OK))
		else $error("inserted result with hit or bad status");

	// An overlong word neither hits nor inserts.
	a_long_no_table: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == STATUS_LONG) |->
		(!result.was_present && !result.inserted))
		else $error("overlong word touched the table");

endmodule

bind word_hash_dedup_table_core whdt_checker u_whdt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.item        (item),
	.result_valid(result_valid),
	.result      (result)
);

### dv/tb_word_hash_dedup_table_core.sv
// ----------------------------------------------------------------------------
// tb_word_hash_dedup_table_core: self-checking bench for the hash dedup table
// Feeds terms one character per input word, predicts every finished hash and
// its table outcome with an independent model, and checks each result word.
// ----------------------------------------------------------------------------
module tb_word_hash_dedup_table_core;
	import whdt_pkg::*;

	// Sender gap settings, in percent of cycles with start held low.
	localparam int GAP_NONE_PCT  = 0;
	localparam int GAP_HEAVY_PCT = 81;
	localparam int GAP_LIGHT_PCT = 14;

	// Cycles left after the last result before a seed write or the end. The
	// longest single operation is a full scan of TABLE_DEPTH entries.
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES    = 16;
	localparam int STALL_LIMIT   = 12 * (TABLE_DEPTH + 3);
	localparam int PRINT_CAP     = 40;

	typedef logic [CHAR_W-1:0] char_list_t[$];

	logic              clk;
	logic              arst_n;
	logic              start     = 1'b0;
	logic              busy;
	item_t             item      = '0;
	logic              result_valid;
	result_t           result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [HASH_W-1:0] cfg_data  = '0;

	word_hash_dedup_table_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// Input words waiting to be sent, and result words the model predicts.
	item_t   pending_chars[$];
	result_t expected_results[$];
	int      idle_pct = GAP_NONE_PCT;

	// Model state: its own copy of the seed register and of the table.
	logic [HASH_W-1:0] seed_q   = '0;
	logic [HASH_W-1:0] hash_acc = '0;
	int                char_pos = 0;
	logic              too_long = 1'b0;
	logic [HASH_W-1:0] stored_hashes[TABLE_DEPTH];
	int                stored_n = 0;

	// Run bookkeeping.
	int error_count   = 0;
	int stall_cycles  = 0;
	int seeds_written = 0;
	int n_terms       = 0;
	int n_inserted    = 0;
	int n_present     = 0;
	int n_full        = 0;
	int n_long        = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_CAP) begin
			$display("MISMATCH at term %0d: %s", n_terms, msg);
		end
		error_count++;
	endtask

	// Advance the model by one accepted character. The seed is loaded only at
	// the first character of a term; characters past MAX_WORD_LEN just mark
	// the term overlong. At the last character the table is scanned in order
	// of insertion, and an absent hash is appended for an insert when room is
	// left. An overlong term never touches the table.
	task automatic hash_char(input item_t it);
		logic [HASH_W-1:0] acc;
		logic [HASH_W-1:0] pos_w;
		logic              hit;
		result_t           r;
		acc = (char_pos == 0 && !too_long) ? seed_q : hash_acc;
		if (char_pos >= MAX_WORD_LEN) begin
			too_long = 1'b1;
		end else begin
			pos_w = HASH_W'(char_pos);
			acc = acc + pos_w * HASH_W'(it.char_code) + (64'd1 << (char_pos % 32));
			char_pos++;
		end
		hash_acc = acc;
		if (it.char_last) begin
			r = '0;
			r.hash_value = acc;
			r.status = STATUS_OK;
			if (too_long) begin
				r.status = STATUS_LONG;
			end else begin
				hit = 1'b0;
				for (int k = 0; k < stored_n; k++) begin
					if (stored_hashes[k] == acc) hit = 1'b1;
				end
				if (hit) begin
					r.was_present = 1'b1;
				end else if (it.kind == KIND_INSERT) begin
					if (stored_n < TABLE_DEPTH) begin
						stored_hashes[stored_n] = acc;
						stored_n++;
						r.inserted = 1'b1;
					end else begin
						r.status = STATUS_FULL;
					end
				end
			end
			r.fill_count = FILL_W'(stored_n);
			expected_results.push_back(r);
			char_pos = 0;
			too_long = 1'b0;
			hash_acc = seed_q;
		end
	endtask

	// Driver. The front of the pending queue is what start presents; it is
	// popped only at the edge that accepts it. While the block is busy the
	// offered word is held, otherwise a random roll may insert a gap. start
	// gets exactly one assignment per edge so it never toggles within a step.
	always @(posedge clk) begin : drive
		logic go;
		if (arst_n) begin
			if (start && !busy) void'(pending_chars.pop_front());
			go = 1'b0;
			if (pending_chars.size() != 0) begin
				if (start && busy) go = 1'b1;
				else go = ($urandom_range(99) >= idle_pct);
			end
			start <= go;
			if (go) item <= pending_chars[0];
		end
	end

	// Monitor. All handshakes are sampled with their values from before the
	// edge, the same values the block itself acts on at that edge.
	always @(posedge clk) begin : watch
		logic took_any;
		result_t want;
		if (arst_n) begin
			took_any = 1'b0;
			if (result_valid) begin
				took_any = 1'b1;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result %h with nothing expected",
						result.hash_value));
				end else begin
					want = expected_results.pop_front();
					if (result.hash_value !== want.hash_value)
						report_mismatch($sformatf("hash_value %h, expected %h",
							result.hash_value, want.hash_value));
					if (result.was_present !== want.was_present)
						report_mismatch($sformatf("was_present %b, expected %b",
							result.was_present, want.was_present));
					if (result.inserted !== want.inserted)
						report_mismatch($sformatf("inserted %b, expected %b",
							result.inserted, want.inserted));
					if (result.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							result.status, want.status));
					if (result.fill_count !== want.fill_count)
						report_mismatch($sformatf("fill_count %0d, expected %0d",
							result.fill_count, want.fill_count));
					n_terms++;
					if (want.inserted) n_inserted++;
					if (want.was_present) n_present++;
					if (want.status == STATUS_FULL) n_full++;
					if (want.status == STATUS_LONG) n_long++;
				end
			end
			// The result of a previous term is popped above before a new
			// character can push a fresh expectation.
			if (start && !busy) begin
				took_any = 1'b1;
				hash_char(item);
			end
			// A seed written at this edge counts only from the next edge on,
			// just as the register in the block updates after the edge.
			if (cfg_valid && cfg_ready) begin
				seed_q = cfg_data;
				took_any = 1'b1;
			end
			stall_cycles = took_any ? 0 : stall_cycles + 1;
		end
	end

	// A term is a run of characters; only the last one carries a kind that
	// matters, so the others get a random kind to show it is ignored.
	task automatic add_term(input logic k, input char_list_t cs);
		item_t it;
		foreach (cs[i]) begin
			it.char_code = cs[i];
			it.char_last = (i == cs.size() - 1);
			it.kind = it.char_last ? k : 1'($urandom_range(1));
			pending_chars.push_back(it);
		end
	endtask

	task automatic add_random_term(input logic k, input int len);
		char_list_t cs;
		for (int i = 0; i < len; i++) cs.push_back(CHAR_W'($urandom_range(255)));
		add_term(k, cs);
	endtask

	// Mostly short terms: one-character terms always hash to seed plus one and
	// two-character ones to one of 256 values, so repeats hit stored entries
	// often. A few longer terms walk the position term through its wrap.
	task automatic add_random_terms(input int count);
		int roll;
		int len;
		logic k;
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 35) len = 1;
			else if (roll < 65) len = 2;
			else if (roll < 90) len = $urandom_range(6, 3);
			else len = $urandom_range(40, 7);
			k = ($urandom_range(99) < 65) ? KIND_INSERT : KIND_LOOKUP;
			add_random_term(k, len);
		end
	endtask

	// Fixed terms with the character extremes, zero included, both kinds,
	// repeats, absent lookups, and non-last characters of the other kind.
	task automatic add_directed_terms();
		add_term(KIND_INSERT, '{8'h01});
		add_term(KIND_INSERT, '{8'hFF});
		add_term(KIND_LOOKUP, '{8'h80});
		add_term(KIND_LOOKUP, '{8'h00, 8'hFF});
		add_term(KIND_INSERT, '{8'h00, 8'hFF});
		add_term(KIND_INSERT, '{8'hFF, 8'hFF, 8'hFF});
		add_term(KIND_LOOKUP, '{8'h55, 8'hAA, 8'h01});
		add_term(KIND_INSERT, '{8'hAA, 8'h55, 8'h00, 8'hFF});
		add_term(KIND_LOOKUP, '{8'hAA, 8'h55, 8'h00, 8'hFF});
	endtask

	// Seed writes happen only when the block is idle, so the handshake simply
	// waits for ready.
	task automatic write_seed(input logic [HASH_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		seeds_written++;
		@(negedge clk);
	endtask

	// Wait until every queued character is taken and every result is back,
	// checked at the falling edge so both clocked blocks have run.
	task automatic drain();
		do @(negedge clk);
		while (pending_chars.size() != 0 || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed terms under the reset seed of zero.
		idle_pct = GAP_NONE_PCT;
		add_directed_terms();
		drain();

		// All-ones seed forces wrapping; one term of exactly the length limit
		// and one a character past it.
		write_seed('1);
		idle_pct = GAP_NONE_PCT;
		add_random_term(KIND_INSERT, MAX_WORD_LEN);
		add_random_term(KIND_INSERT, MAX_WORD_LEN + 1);
		add_random_terms(10);
		drain();

		write_seed({$urandom, $urandom});
		idle_pct = GAP_HEAVY_PCT;
		add_random_terms(20);
		add_random_term(KIND_LOOKUP, MAX_WORD_LEN + 2);
		add_random_terms(5);
		drain();

		write_seed('0);
		idle_pct = GAP_LIGHT_PCT;
		add_random_terms(20);
		drain();

		write_seed({$urandom, $urandom});
		idle_pct = GAP_NONE_PCT;
		add_random_terms(20);
		drain();

		// Fill the table: each one-character insert under a fresh seed adds a
		// distinct entry, which is the cheapest way to reach a full table.
		while (stored_n < TABLE_DEPTH) begin
			write_seed({$urandom, $urandom});
			case ($urandom_range(2))
				0: idle_pct = GAP_NONE_PCT;
				1: idle_pct = GAP_HEAVY_PCT;
				default: idle_pct = GAP_LIGHT_PCT;
			endcase
			add_random_term(KIND_INSERT, 1);
			drain();
		end

		// Full table: stored terms still match, absent inserts are refused,
		// lookups leave the table alone.
		write_seed('0);
		idle_pct = GAP_HEAVY_PCT;
		add_directed_terms();
		add_random_terms(20);
		drain();

		write_seed('1);
		idle_pct = GAP_LIGHT_PCT;
		add_random_terms(20);
		drain();

		repeat (END_CYCLES) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived",
				expected_results.size()));
		$display("Checked %0d terms: %0d inserted, %0d already stored,",
			n_terms, n_inserted, n_present);
		$display("%0d refused full, %0d overlong; seed written %0d times, table %0d of %0d.",
			n_full, n_long, seeds_written, stored_n, TABLE_DEPTH);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog: ends the run when no handshake of any kind has happened for
	// far longer than the slowest scan of a full table.
	initial begin : watchdog
		wait (stall_cycles >= STALL_LIMIT);
		$display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
